FILE: hdl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

   localparam logic [3:0] FMT_G8       = 4'd0;
   localparam logic [3:0] FMT_RGB565   = 4'd1;
   localparam logic [3:0] FMT_BGR565   = 4'd2;
   localparam logic [3:0] FMT_RGBA5551 = 4'd3;
   localparam logic [3:0] FMT_BGRA5551 = 4'd4;
   localparam logic [3:0] FMT_RGBA4444 = 4'd5;
   localparam logic [3:0] FMT_BGRA4444 = 4'd6;
   localparam logic [3:0] FMT_RGB888   = 4'd7;
   localparam logic [3:0] FMT_BGR888   = 4'd8;
   localparam logic [3:0] FMT_RGBA8888 = 4'd9;
   localparam logic [3:0] FMT_BGRA8888 = 4'd10;
   localparam logic [3:0] FMT_ARGB8888 = 4'd11;
   localparam logic [3:0] FMT_ABGR8888 = 4'd12;

   localparam logic [3:0] FMT_RESET = FMT_RGBA8888;

   localparam logic [0:0] CSR_SOURCE_FORMAT = 1'd0;
   localparam logic [0:0] CSR_TARGET_FORMAT = 1'd1;

   // floor(s / 3) == (s * 683) >> 11 for every s below 2048
   localparam logic [9:0] DIV3_RECIP = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } rgba_type;

   function automatic logic fmt_is_bgr(input logic [3:0] code);
      return (code != FMT_G8) && !code[0];
   endfunction

   function automatic logic fmt_is_valid(input logic [3:0] code);
      return code <= FMT_ABGR8888;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/pfc_unpack.sv
`default_nettype none

module pfc_unpack
   import pfc_pkg::*;
(
   input  wire logic [3:0]  code,
   input  wire logic [31:0] pixel,
   input  wire logic        swap_rb,
   output rgba_type         rgba
);

   rgba_type   dec;
   logic [15:0] w;
   logic [7:0]  b0, b1, b2, b3;

   assign w  = pixel[15:0];
   assign b0 = pixel[7:0];
   assign b1 = pixel[15:8];
   assign b2 = pixel[23:16];
   assign b3 = pixel[31:24];

   always_comb begin
      dec = '0;
      unique case (code)
         FMT_G8: begin
            dec = '{r: b0, g: b0, b: b0, a: 8'hFF};
         end
         FMT_RGB565, FMT_BGR565: begin
            dec.r = {w[15:11], w[15:13]};
            dec.g = {w[10:5], w[10:9]};
            dec.b = {w[4:0], w[4:2]};
            dec.a = 8'hFF;
         end
         FMT_RGBA5551, FMT_BGRA5551: begin
            dec.r = {w[15:11], w[15:13]};
            dec.g = {w[10:6], w[10:8]};
            dec.b = {w[5:1], w[5:3]};
            dec.a = {8{w[0]}};
         end
         FMT_RGBA4444, FMT_BGRA4444: begin
            dec.r = {w[15:12], w[15:12]};
            dec.g = {w[11:8], w[11:8]};
            dec.b = {w[7:4], w[7:4]};
            dec.a = {w[3:0], w[3:0]};
         end
         FMT_RGB888, FMT_BGR888: begin
            dec = '{r: b0, g: b1, b: b2, a: 8'hFF};
         end
         FMT_RGBA8888, FMT_BGRA8888: begin
            dec = '{r: b0, g: b1, b: b2, a: b3};
         end
         FMT_ARGB8888, FMT_ABGR8888: begin
            dec = '{r: b1, g: b2, b: b3, a: b0};
         end
         default: begin
            dec = '0;
         end
      endcase
   end

   always_comb begin
      rgba = dec;
      if (swap_rb) begin
         rgba.r = dec.b;
         rgba.b = dec.r;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pfc_pack.sv
`default_nettype none

module pfc_pack
   import pfc_pkg::*;
(
   input  wire logic [3:0]  code,
   input  wire rgba_type    rgba,
   output logic [31:0]      pixel,
   output logic [2:0]       byte_count
);

   logic [9:0]  gray_sum;
   logic [19:0] gray_prod;
   logic [7:0]  gray;

   assign gray_sum  = 10'(rgba.r) + 10'(rgba.g) + 10'(rgba.b);
   assign gray_prod = 20'(gray_sum) * 20'(DIV3_RECIP);
   assign gray      = gray_prod[DIV3_SHIFT +: 8];

   always_comb begin
      pixel      = '0;
      byte_count = 3'd4;
      unique case (code)
         FMT_G8: begin
            pixel      = {24'd0, gray};
            byte_count = 3'd1;
         end
         FMT_RGB565, FMT_BGR565: begin
            pixel      = {16'd0, rgba.r[7:3], rgba.g[7:2], rgba.b[7:3]};
            byte_count = 3'd2;
         end
         FMT_RGBA5551, FMT_BGRA5551: begin
            pixel      = {16'd0, rgba.r[7:3], rgba.g[7:3], rgba.b[7:3], rgba.a[7]};
            byte_count = 3'd2;
         end
         FMT_RGBA4444, FMT_BGRA4444: begin
            pixel      = {16'd0, rgba.r[7:4], rgba.g[7:4], rgba.b[7:4], rgba.a[7:4]};
            byte_count = 3'd2;
         end
         FMT_RGB888, FMT_BGR888: begin
            pixel      = {8'd0, rgba.b, rgba.g, rgba.r};
            byte_count = 3'd3;
         end
         FMT_RGBA8888, FMT_BGRA8888: begin
            pixel      = {rgba.a, rgba.b, rgba.g, rgba.r};
            byte_count = 3'd4;
         end
         FMT_ARGB8888, FMT_ABGR8888: begin
            pixel      = {rgba.b, rgba.g, rgba.r, rgba.a};
            byte_count = 3'd4;
         end
         default: begin
            pixel      = '0;
            byte_count = 3'd0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/pixel_format_converter_core.sv
`default_nettype none

// Pixel format converter: one pixel per clock. A word taken with start lands
// in the input register, passes through the unpack / red-blue swap / pack
// logic (the gray divide by three is a constant multiply) and is registered
// on the rsp_ ports for exactly one cycle; the receiver cannot stall it, so
// busy stays low and a new pixel may follow every cycle. csr_ready is always
// high; write source_format (index 0) and target_format (index 1) only while
// no pixel is in flight. If either format code is above 12, the result has
// pixel_out and byte_count zero and rsp_unsupported set.
module pixel_format_converter_core
   import pfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_pixel_in,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_pixel_out,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_unsupported,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [3:0]  csr_data
);

   logic [3:0]  src_fmt_ff, src_fmt_in;
   logic [3:0]  dst_fmt_ff, dst_fmt_in;
   logic        in_valid_ff;
   logic [31:0] in_pixel_ff;
   logic        out_valid_ff;
   logic [31:0] out_pixel_ff, out_pixel_in;
   logic [2:0]  out_count_ff, out_count_in;
   logic        out_unsup_ff, out_unsup_in;

   rgba_type    rgba;
   logic [31:0] packed_pixel;
   logic [2:0]  packed_count;
   logic        swap_rb;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      src_fmt_in = src_fmt_ff;
      dst_fmt_in = dst_fmt_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_FORMAT: src_fmt_in = csr_data;
            CSR_TARGET_FORMAT: dst_fmt_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= FMT_RESET;
         dst_fmt_ff <= FMT_RESET;
      end else begin
         src_fmt_ff <= src_fmt_in;
         dst_fmt_ff <= dst_fmt_in;
      end
   end

   // capture the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_pixel_ff <= req_pixel_in;
      end
   end

   assign swap_rb = fmt_is_bgr(src_fmt_ff) != fmt_is_bgr(dst_fmt_ff);

   pfc_unpack u_unpack (
      .code    (src_fmt_ff),
      .pixel   (in_pixel_ff),
      .swap_rb (swap_rb),
      .rgba    (rgba)
   );

   pfc_pack u_pack (
      .code       (dst_fmt_ff),
      .rgba       (rgba),
      .pixel      (packed_pixel),
      .byte_count (packed_count)
   );

   always_comb begin
      if (fmt_is_valid(src_fmt_ff) && fmt_is_valid(dst_fmt_ff)) begin
         out_pixel_in = packed_pixel;
         out_count_in = packed_count;
         out_unsup_in = 1'b0;
      end else begin
         out_pixel_in = '0;
         out_count_in = '0;
         out_unsup_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_count_ff <= out_count_in;
         out_unsup_ff <= out_unsup_in;
      end
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_pixel_out   = out_pixel_ff;
   assign rsp_byte_count  = out_count_ff;
   assign rsp_unsupported = out_unsup_ff;

   // every accepted word comes out on rsp_strobe after the input and output registers
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word did not produce a result");

   a_unsup_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_unsupported) |-> (rsp_pixel_out == 32'd0 && rsp_byte_count == 3'd0))
      else $error("unsupported result carries data");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_unsupported) |-> (rsp_byte_count != 3'd0 && rsp_byte_count <= 3'd4))
      else $error("byte count out of range");

   a_upper_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_byte_count == 3'd1) |-> (rsp_pixel_out[31:8] == 24'd0))
      else $error("unused bytes not zero");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_valid_ff))
      else $error("result without an accepted word");

endmodule

`default_nettype wire
